// ===== src/gal_pkg.sv =====
// ----------------------------------------------------------------------------
// gal_pkg: shared types and constants of the gyro activity level block
// Field widths, register indexes and the structs passed between modules.
// ----------------------------------------------------------------------------
package gal_pkg;

    // Input and result field widths
    localparam int RATE_W   = 8;
    localparam int SUMSQ_W  = 16;
    localparam int INDEX_W  = 32;
    localparam int LEVEL_W  = 16;
    localparam int MAG_W    = 24;

    // Configuration register widths
    localparam int WEIGHT_W = 17;
    localparam int GAIN_W   = 20;
    localparam int LIMIT_W  = 16;
    localparam int CFG_W    = 20;
    localparam int CFG_IX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_WEIGHT = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_GAIN   = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_LIMIT  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 17'd6554;
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 20'd114688;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 16'd1000;

    // Filter weight of one in Q16, and half an LSB for rounding
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
    localparam logic [15:0]         ROUND_HALF = 16'd32768;

    // Square root: two result bits per cycle
    localparam int ROOT_STEPS = MAG_W / 2;
    localparam int STEP_W     = $clog2(ROOT_STEPS + 1);
    localparam int REM_W      = MAG_W + 3;

    // One classified item waiting for the back end
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [SUMSQ_W-1:0] sumsq;
    } t_job;

    // Configuration seen by the back end
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [GAIN_W-1:0]   gain;
        logic [LIMIT_W-1:0]  limit;
    } t_cfg;

    // Queue status towards the back end
    typedef struct packed {
        logic not_empty;
        logic not_full;
    } t_qstat;

endpackage

// ===== src/gyro_activity_level_core.sv =====
// ----------------------------------------------------------------------------
// gyro_activity_level_core: smoothed gyro rate magnitude as an activity level
// Top level joining the input stage, the job queue and the arithmetic back end.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one gyro item per handshake: rate_x, rate_y, rate_z, signed
//   bytes. m_axis returns one result per item: the 32-bit sample index and the
//   activity level in tenths, saturated at the configured limit.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data while
//   the block is idle; indexes 0..2 are weight, gain and limit.
// An item passes the queue, then the back end loads it and runs the square root,
//   the multiply, sum and scale steps and the output register, in that order.
// The back end takes a new item only once it is idle again; its square-root unit
//   produces two bits of the 24-bit root per cycle.
// A two-entry queue lets the input side take two more items while one is in
//   work. When the receiver stalls, the result holds in the output register,
//   the back end waits with the next result and the queue fills; s_axis_tready
//   falls once it is full.
// Reset (synchronous, active low) clears the filter state, the sample index,
//   the queue and the output valid, and loads the default configuration.
// ----------------------------------------------------------------------------
module gyro_activity_level_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // rate_x, rate_y, rate_z
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [47:0]                   m_axis_tdata,  // sample_index, activity_tenths
    input  logic                          i_cfg_we,
    input  logic [gal_pkg::CFG_IX_W-1:0]  i_cfg_index,
    input  logic [gal_pkg::CFG_W-1:0]     i_cfg_data
);
    import gal_pkg::*;

    t_cfg   r_cfg;
    t_job   push_job;
    t_job   head_job;
    t_qstat qstat;
    logic   push;
    logic   pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.weight <= WEIGHT_RST;
            r_cfg.gain   <= GAIN_RST;
            r_cfg.limit  <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WEIGHT: r_cfg.weight <= i_cfg_data[WEIGHT_W-1:0];
                CFG_GAIN:   r_cfg.gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_LIMIT:  r_cfg.limit  <= i_cfg_data[LIMIT_W-1:0];
                default:    ;
            endcase
        end
    end

    gal_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_q_not_full  (qstat.not_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    gal_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (qstat)
    );

    gal_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_qstat       (qstat),
        .i_job         (head_job),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== src/gal_front.sv =====
// ----------------------------------------------------------------------------
// gal_front: input stage of the gyro activity level block
// Accepts gyro items, forms the sum of squares and tags each with its index.
// ----------------------------------------------------------------------------
module gal_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [23:0]                 s_axis_tdata,  // rate_x, rate_y, rate_z
    input  logic                        i_q_not_full,
    output logic                        o_push,
    output gal_pkg::t_job               o_job
);
    import gal_pkg::*;

    logic [INDEX_W-1:0]         r_count;
    logic signed [RATE_W-1:0]   rx, ry, rz;
    logic signed [2*RATE_W-1:0] px, py, pz;
    logic [SUMSQ_W-1:0]         sq_x, sq_y, sq_z;

    assign rx = s_axis_tdata[7:0];
    assign ry = s_axis_tdata[15:8];
    assign rz = s_axis_tdata[23:16];

    // Full-width signed products
    assign px = rx * rx;
    assign py = ry * ry;
    assign pz = rz * rz;

    // Squares fit 15 bits; the sum of three stays below 2^16
    assign sq_x = SUMSQ_W'(unsigned'(px));
    assign sq_y = SUMSQ_W'(unsigned'(py));
    assign sq_z = SUMSQ_W'(unsigned'(pz));

    assign s_axis_tready = i_q_not_full;
    assign o_push        = s_axis_tvalid && i_q_not_full;
    assign o_job.index   = r_count;
    assign o_job.sumsq   = sq_x + sq_y + sq_z;

    // Sample index, wrapping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= r_count + 1'b1;
        end
    end

endmodule

// ===== src/gal_queue.sv =====
// ----------------------------------------------------------------------------
// gal_queue: two-entry queue between front and back end
// Lets the front take a new item while the back end is still busy.
// ----------------------------------------------------------------------------
module gal_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gal_pkg::t_job   i_job,
    input  logic            i_pop,
    output gal_pkg::t_job   o_job,
    output gal_pkg::t_qstat o_stat
);
    import gal_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_fill;

    assign o_job            = r_mem[r_rptr];
    assign o_stat.not_empty = (r_fill != 2'd0);
    assign o_stat.not_full  = (r_fill != 2'd2);

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

// ===== src/gal_back.sv =====
// ----------------------------------------------------------------------------
// gal_back: arithmetic back end of the gyro activity level block
// Square root, moving average, gain scaling and the output register.
// ----------------------------------------------------------------------------
module gal_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gal_pkg::t_cfg               i_cfg,
    input  gal_pkg::t_qstat             i_qstat,
    input  gal_pkg::t_job               i_job,
    output logic                        o_pop,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [47:0]                 m_axis_tdata   // sample_index, activity_tenths
);
    import gal_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_MUL,
        S_SUM,
        S_SCALE,
        S_OUT
    } t_state;

    t_state                     r_state;
    logic [INDEX_W-1:0]         r_index;
    logic [SUMSQ_W-1:0]         r_rad;
    logic [REM_W-1:0]           r_rem;
    logic [MAG_W-1:0]           r_root;
    logic [STEP_W-1:0]          r_step;
    logic [MAG_W-1:0]           r_smooth;
    logic [WEIGHT_W+MAG_W-1:0]  r_p_old;
    logic [WEIGHT_W+MAG_W-1:0]  r_p_new;
    logic [MAG_W+GAIN_W-1:0]    r_scaled;
    logic                       r_out_valid;
    logic [INDEX_W-1:0]         r_out_index;
    logic [LEVEL_W-1:0]         r_out_level;

    logic [REM_W-1:0]           n_rem;
    logic [MAG_W-1:0]           n_root;
    logic [WEIGHT_W-1:0]        w_new;
    logic [WEIGHT_W-1:0]        w_old;
    logic [WEIGHT_W+MAG_W:0]    acc;
    logic [GAIN_W+MAG_W-GAIN_W-13:0] lvl_hi;
    logic [LEVEL_W-1:0]         level;

    // Two restoring square-root steps per cycle on the radicand (sumsq << 32)
    always_comb begin
        logic [REM_W-1:0] rem_v;
        logic [REM_W-1:0] trial;
        logic [MAG_W-1:0] root_v;
        logic [1:0]       pair;
        rem_v  = r_rem;
        root_v = r_root;
        for (int k = 0; k < 2; k++) begin
            pair  = (k == 0) ? r_rad[SUMSQ_W-1 -: 2] : r_rad[SUMSQ_W-3 -: 2];
            rem_v = {rem_v[REM_W-3:0], pair};
            trial = {1'b0, root_v, 2'b01};
            if (rem_v >= trial) begin
                rem_v  = rem_v - trial;
                root_v = {root_v[MAG_W-2:0], 1'b1};
            end else begin
                root_v = {root_v[MAG_W-2:0], 1'b0};
            end
        end
        n_rem  = rem_v;
        n_root = root_v;
    end

    // Weight above one acts as one
    assign w_new = i_cfg.weight[WEIGHT_W-1] ? WEIGHT_ONE : i_cfg.weight;
    assign w_old = WEIGHT_ONE - w_new;

    // Rounded filter sum
    assign acc = {1'b0, r_p_old} + {1'b0, r_p_new} + (WEIGHT_W+MAG_W+1)'(ROUND_HALF);

    // Scaled level stays below 2^12; saturate at the limit
    assign lvl_hi = r_scaled[MAG_W+GAIN_W-1:32];
    assign level  = (LEVEL_W'(lvl_hi) > i_cfg.limit) ? i_cfg.limit : LEVEL_W'(lvl_hi);

    assign o_pop         = (r_state == S_IDLE) && i_qstat.not_empty;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_level, r_out_index};

    // Sequencer, filter state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_smooth    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Result taken; S_OUT loads the register itself
            if (m_axis_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_qstat.not_empty) begin
                        r_index <= i_job.index;
                        r_rad   <= i_job.sumsq;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_step  <= '0;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_rad  <= {r_rad[SUMSQ_W-5:0], 4'b0000};
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(ROOT_STEPS - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_p_old <= w_old * r_smooth;
                    r_p_new <= w_new * r_root;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_smooth <= acc[MAG_W+15:16];
                    r_state  <= S_SCALE;
                end
                S_SCALE: begin
                    r_scaled <= r_smooth * i_cfg.gain;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_index <= r_index;
                        r_out_level <= level;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/gal_checker.sv =====
// ----------------------------------------------------------------------------
// gal_checker: port-level checks of the gyro activity level block
// Watches reset behaviour, result ordering and output stalls.
// ----------------------------------------------------------------------------
module gal_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata
);

    logic [31:0] r_expect;

    // Index the next result must carry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect <= '0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_expect <= r_expect + 32'd1;
        end
    end

    // Reset leaves no result pending and the input ready
    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("result pending or input blocked after reset");

    // Results come in order, none lost or repeated
    a_in_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:0] == r_expect)
        else $error("result index out of sequence");

    // A stalled result holds
    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind gyro_activity_level_core gal_checker u_gal_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
